/* hw/rtl/jsu_pkg.sv */
`default_nettype none

package jsu_pkg;

    // Hard ceiling on the decoded string length; the register limit is clipped to it.
    localparam int LIMIT_MAX = 4096;

    localparam int CFG_W = 13;
    localparam logic [CFG_W-1:0] MAX_BYTES_RESET = 13'd4096;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Decoder modes
    localparam logic [3:0] MODE_IDLE    = 4'd0;
    localparam logic [3:0] MODE_STR     = 4'd1;
    localparam logic [3:0] MODE_ESC     = 4'd2;
    localparam logic [3:0] MODE_HEX1    = 4'd3;
    localparam logic [3:0] MODE_SURR_BS = 4'd4;
    localparam logic [3:0] MODE_SURR_U  = 4'd5;
    localparam logic [3:0] MODE_HEX2    = 4'd6;

    // Register index of the configuration space
    localparam int REG_MAX_STRING_BYTES = 0;

    // All results caused by one input transaction
    typedef struct packed {
        logic            valid;
        logic [1:0]      kind;
        logic [1:0]      last_idx;
        logic [3:0][7:0] bytes;
    } jsu_group_t;

endpackage

`default_nettype wire

/* hw/rtl/jsu_ifs.sv */
`default_nettype none

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output result_kind, output out_byte, output last_of_run,
                    input ready);
    modport sink (input valid, input result_kind, input out_byte, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/jsu_decode.sv */
`default_nettype none

module jsu_decode import jsu_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       in_byte,
    input  wire logic             end_of_input,
    input  wire logic [CFG_W-1:0] max_bytes,
    output jsu_group_t            grp
);

    logic [3:0]       mode_reg,  mode_next;
    logic [15:0]      acc_reg,   acc_next;
    logic [1:0]       cnt_reg,   cnt_next;
    logic [9:0]       hi_reg,    hi_next;
    logic [CFG_W-1:0] count_reg, count_next;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    logic [4:0]      hv;
    logic [15:0]     acc_shift;
    logic [20:0]     cp;
    logic            do_fail;
    logic            do_emit;
    logic [2:0]      emit_len;
    logic [3:0][7:0] emit_b;
    logic [16:0]     lim;
    logic [16:0]     need;

    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        hi_next    = hi_reg;
        count_next = count_reg;
        grp        = '0;
        grp.kind   = KIND_DATA;
        do_fail    = 1'b0;
        do_emit    = 1'b0;
        emit_len   = 3'd1;
        emit_b     = '0;
        cp         = 21'd0;
        hv         = hex_val(in_byte);
        acc_shift  = {acc_reg[11:0], hv[3:0]};

        if (end_of_input) begin
            do_fail = 1'b1;
        end else begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    if (in_byte == 8'h22) begin
                        mode_next  = MODE_STR;
                        count_next = '0;
                    end else if (!(in_byte == 8'h20 || in_byte == 8'h09 ||
                                   in_byte == 8'h0D || in_byte == 8'h0A)) begin
                        do_fail = 1'b1;
                    end
                end
                MODE_STR:
                begin
                    if (in_byte == 8'h22) begin
                        mode_next = MODE_IDLE;
                        grp.valid = 1'b1;
                        grp.kind  = KIND_CLOSE;
                    end else if (in_byte < 8'h20) begin
                        do_fail = 1'b1;
                    end else if (in_byte == 8'h5C) begin
                        mode_next = MODE_ESC;
                    end else begin
                        do_emit   = 1'b1;
                        emit_b[0] = in_byte;
                    end
                end
                MODE_ESC:
                begin
                    do_emit = 1'b1;
                    case (in_byte)
                        8'h22:   emit_b[0] = 8'h22;
                        8'h5C:   emit_b[0] = 8'h5C;
                        8'h2F:   emit_b[0] = 8'h2F;
                        8'h62:   emit_b[0] = 8'h08;
                        8'h66:   emit_b[0] = 8'h0C;
                        8'h6E:   emit_b[0] = 8'h0A;
                        8'h72:   emit_b[0] = 8'h0D;
                        8'h74:   emit_b[0] = 8'h09;
                        8'h75:
                        begin
                            do_emit   = 1'b0;
                            mode_next = MODE_HEX1;
                            acc_next  = '0;
                            cnt_next  = '0;
                        end
                        default:
                        begin
                            do_emit = 1'b0;
                            do_fail = 1'b1;
                        end
                    endcase
                end
                MODE_SURR_BS:
                begin
                    if (in_byte != 8'h5C) do_fail = 1'b1;
                    else mode_next = MODE_SURR_U;
                end
                MODE_SURR_U:
                begin
                    if (in_byte != 8'h75) begin
                        do_fail = 1'b1;
                    end else begin
                        mode_next = MODE_HEX2;
                        acc_next  = '0;
                        cnt_next  = '0;
                    end
                end
                MODE_HEX1, MODE_HEX2:
                begin
                    if (!hv[4]) begin
                        do_fail = 1'b1;
                    end else begin
                        acc_next = acc_shift;
                        if (cnt_reg != 2'd3) begin
                            cnt_next = cnt_reg + 2'd1;
                        end else begin
                            cnt_next = '0;
                            if (mode_reg == MODE_HEX1) begin
                                if (acc_shift >= 16'hD800 && acc_shift <= 16'hDBFF) begin
                                    hi_next   = acc_shift[9:0];
                                    mode_next = MODE_SURR_BS;
                                end else if (acc_shift >= 16'hDC00) begin
                                    if (acc_shift <= 16'hDFFF) do_fail = 1'b1;
                                    else do_emit = 1'b1;
                                end else begin
                                    do_emit = 1'b1;
                                end
                                cp = {5'd0, acc_shift};
                            end else begin
                                if (acc_shift < 16'hDC00 || acc_shift > 16'hDFFF) begin
                                    do_fail = 1'b1;
                                end else begin
                                    do_emit = 1'b1;
                                end
                                cp = 21'h10000 + {1'b0, hi_reg, acc_shift[9:0]};
                            end
                            // UTF-8 encode of the finished code point
                            if (cp <= 21'h7F) begin
                                emit_len  = 3'd1;
                                emit_b[0] = cp[7:0];
                            end else if (cp <= 21'h7FF) begin
                                emit_len  = 3'd2;
                                emit_b[0] = 8'hC0 | {3'd0, cp[10:6]};
                                emit_b[1] = {2'b10, cp[5:0]};
                            end else if (cp <= 21'hFFFF) begin
                                emit_len  = 3'd3;
                                emit_b[0] = 8'hE0 | {4'd0, cp[15:12]};
                                emit_b[1] = {2'b10, cp[11:6]};
                                emit_b[2] = {2'b10, cp[5:0]};
                            end else begin
                                emit_len  = 3'd4;
                                emit_b[0] = 8'hF0 | {5'd0, cp[20:18]};
                                emit_b[1] = {2'b10, cp[17:12]};
                                emit_b[2] = {2'b10, cp[11:6]};
                                emit_b[3] = {2'b10, cp[5:0]};
                            end
                        end
                    end
                end
                default:
                begin
                    do_fail = 1'b1;
                end
            endcase
        end

        lim  = (17'(max_bytes) > 17'(LIMIT_MAX)) ? 17'(LIMIT_MAX) : 17'(max_bytes);
        need = 17'(count_reg) + 17'(emit_len);

        if (do_emit) begin
            if (need > lim) begin
                do_fail = 1'b1;
            end else begin
                grp.valid    = 1'b1;
                grp.kind     = KIND_DATA;
                grp.last_idx = 2'(emit_len - 3'd1);
                grp.bytes    = emit_b;
                count_next   = CFG_W'(need);
                mode_next    = MODE_STR;
            end
        end

        if (do_fail) begin
            mode_next    = MODE_IDLE;
            acc_next     = '0;
            cnt_next     = '0;
            hi_next      = '0;
            grp.valid    = 1'b1;
            grp.kind     = KIND_ERROR;
            grp.last_idx = 2'd0;
            grp.bytes    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_IDLE;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            hi_reg    <= '0;
            count_reg <= '0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            hi_reg    <= hi_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/jsu_emit.sv */
`default_nettype none

module jsu_emit import jsu_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire jsu_group_t  grp_in,
    output logic             load_ready,
    jsu_out_if.source        out_ch
);

    jsu_group_t grp_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       take;
    logic       done;

    assign take       = valid_reg && out_ch.ready;
    assign done       = take && (idx_reg == grp_reg.last_idx);
    assign load_ready = !valid_reg || done;

    assign out_ch.valid       = valid_reg;
    assign out_ch.result_kind = grp_reg.kind;
    assign out_ch.out_byte    = (grp_reg.kind == KIND_DATA) ? grp_reg.bytes[idx_reg] : 8'd0;
    assign out_ch.last_of_run = (idx_reg == grp_reg.last_idx);

    // Hold the group's payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (load && grp_in.valid) grp_reg <= grp_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load && grp_in.valid) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (done) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (take) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/json_string_unescape_utf8.sv */
`default_nettype none

// JSON string unescaper with UTF-8 output. Feed one byte of JSON text per
// input transaction (or an end-of-data mark); the block skips leading
// whitespace, expects an opening quote, and returns the decoded string as a
// stream of result transactions: data bytes, then a close or an error
// result, with last_of_run marking the final result of each input
// transaction. \uXXXX escapes (including surrogate pairs) expand to 1..4
// UTF-8 bytes. The limit on decoded bytes is the max_string_bytes register
// at byte address 0, clipped to LIMIT_MAX. Rate: an input byte is decoded
// in one pass into a result register, so one input transaction is taken
// per cycle while the result register is free; results leave one per
// cycle while the output is ready, and input is held (ready low) until
// the last result of a transaction leaves. The next input is taken in
// the same cycle the last result of the previous one leaves.
module json_string_unescape_utf8 import jsu_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    jsu_in_if.sink           in_ch,
    jsu_out_if.source        out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [CFG_W-1:0] max_bytes_reg;
    logic             cfg_write;
    logic             load_ready;
    logic             accept;
    jsu_group_t       grp;

    // Configuration: single register, every word address in the port maps to it
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (32'(paddr >> 2) == 32'(REG_MAX_STRING_BYTES)) ?
                       {{(32-CFG_W){1'b0}}, max_bytes_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_bytes_reg <= MAX_BYTES_RESET;
        end else if (cfg_write && (32'(paddr >> 2) == 32'(REG_MAX_STRING_BYTES))) begin
            max_bytes_reg <= pwdata[CFG_W-1:0];
        end
    end

    // Take a new byte whenever the result register is free or drains this cycle
    assign in_ch.ready = load_ready;
    assign accept      = in_ch.valid && load_ready;

    jsu_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (in_ch.in_byte),
        .end_of_input (in_ch.end_of_input),
        .max_bytes    (max_bytes_reg),
        .grp          (grp)
    );

    jsu_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .grp_in     (grp),
        .load_ready (load_ready),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire
